/* rtl/core/bresenham_line_stepper_defines.svh */
// ----------------------------------------------------------------------------
// bresenham line stepper assertion macros
// shared property templates for the concurrent checks in the top level
// ----------------------------------------------------------------------------
`ifndef BRESENHAM_LINE_STEPPER_DEFINES_SVH
`define BRESENHAM_LINE_STEPPER_DEFINES_SVH

// same-cycle implication under reset
`define BLS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication under reset
`define BLS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/bls_pkg.sv */
// ----------------------------------------------------------------------------
// bls_pkg
// widths, octant codes and controller/datapath interface types
// ----------------------------------------------------------------------------
`default_nettype none

package bls_pkg;

    localparam int COORD_BITS = 12;
    localparam int COLOR_BITS = 24;
    localparam int ERR_BITS   = COORD_BITS + 3;
    localparam int EXT_BITS   = ERR_BITS - COORD_BITS;
    localparam int MODE_BITS  = 3;

    localparam logic [MODE_BITS-1:0] MODE_VERT        = 3'd0;
    localparam logic [MODE_BITS-1:0] MODE_SHALLOW_UP   = 3'd1;
    localparam logic [MODE_BITS-1:0] MODE_STEEP_UP     = 3'd2;
    localparam logic [MODE_BITS-1:0] MODE_SHALLOW_DOWN = 3'd3;
    localparam logic [MODE_BITS-1:0] MODE_STEEP_DOWN   = 3'd4;

    localparam logic [COORD_BITS-1:0]      COORD_ONE = COORD_BITS'(1);
    localparam logic signed [ERR_BITS-1:0] ERR_ZERO  = '0;

    localparam logic ACTION_LOAD = 1'b0;
    localparam logic ACTION_STEP = 1'b1;

    typedef struct packed {
        logic load;
        logic setup;
        logic emit;
    } bls_cmd_t;

    typedef struct packed {
        logic last;
    } bls_stat_t;

endpackage

`default_nettype wire

/* rtl/core/bresenham_line_stepper.sv */
// ----------------------------------------------------------------------------
// bresenham_line_stepper
// A load request (action 0) takes two endpoints and a color. The load cycle
// orders the endpoints so x rises; the setup state then classifies the line
// and sets up the error term, during which the input is stalled. After that
// every step request (action 1) yields one pixel per clock while the output
// is not stalled, set by the single add and compare on the error term in the
// datapath; the pixel sits in an output register, so the next step is taken
// in the same cycle the previous pixel is drained. The final pixel carries
// last_pixel and returns the block to idle; a step while idle is consumed
// without a result, and a load while a line is running abandons it.
// ----------------------------------------------------------------------------
`default_nettype none

`include "bresenham_line_stepper_defines.svh"

module bresenham_line_stepper
    import bls_pkg::*;
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    output logic                              in_stall,
    input  wire logic                         action,
    input  wire logic signed [COORD_BITS-1:0] first_x,
    input  wire logic signed [COORD_BITS-1:0] first_y,
    input  wire logic signed [COORD_BITS-1:0] second_x,
    input  wire logic signed [COORD_BITS-1:0] second_y,
    input  wire logic [COLOR_BITS-1:0]        line_color,
    output logic                              out_valid,
    input  wire logic                         out_stall,
    output logic signed [COORD_BITS-1:0]      pixel_x,
    output logic signed [COORD_BITS-1:0]      pixel_y,
    output logic [COLOR_BITS-1:0]             pixel_color,
    output logic                              last_pixel
);

    bls_cmd_t  cmd;
    bls_stat_t stat;
    logic      busy;

    bls_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .action    (action),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .stat      (stat),
        .cmd       (cmd),
        .busy      (busy)
    );

    bls_datapath u_datapath (
        .clk         (clk),
        .cmd         (cmd),
        .stat        (stat),
        .first_x     (first_x),
        .first_y     (first_y),
        .second_x    (second_x),
        .second_y    (second_y),
        .line_color  (line_color),
        .pixel_x     (pixel_x),
        .pixel_y     (pixel_y),
        .pixel_color (pixel_color),
        .last_pixel  (last_pixel)
    );

    `BLS_ASSERT_NEXT(a_emit_shows_pixel, cmd.emit, out_valid, "emitted pixel not presented")
    `BLS_ASSERT_NEXT(a_load_stalls_setup, cmd.load, in_stall && busy, "no setup cycle after load")
    `BLS_ASSERT_NEXT(a_last_goes_idle, cmd.emit && stat.last, !busy, "still busy after last pixel")
    `BLS_ASSERT_NOW(a_emit_only_busy, cmd.emit, busy, "pixel emitted while idle")

endmodule

`default_nettype wire

/* rtl/core/bls_ctrl.sv */
// ----------------------------------------------------------------------------
// bls_ctrl
// line state machine, input stall and output valid register
// ----------------------------------------------------------------------------
`default_nettype none

module bls_ctrl
    import bls_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_stall,
    input  wire logic      action,
    output logic           out_valid,
    input  wire logic      out_stall,
    input  wire bls_stat_t stat,
    output bls_cmd_t       cmd,
    output logic           busy
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SETUP = 2'd1;
    localparam logic [1:0] ST_RUN   = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       accept;

    assign in_stall = (state_reg == ST_SETUP) || (out_valid_reg && out_stall);
    assign accept   = in_valid && !in_stall;

    assign cmd.load  = accept && (action == ACTION_LOAD);
    assign cmd.setup = (state_reg == ST_SETUP);
    assign cmd.emit  = accept && (action == ACTION_STEP) && (state_reg == ST_RUN);

    assign busy      = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd.load)
                begin
                    state_next = ST_SETUP;
                end
            end
            ST_SETUP:
            begin
                state_next = ST_RUN;
            end
            ST_RUN:
            begin
                if (cmd.load)
                begin
                    state_next = ST_SETUP;
                end
                else if (cmd.emit && stat.last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = cmd.emit || (out_valid_reg && out_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

/* rtl/core/bls_datapath.sv */
// ----------------------------------------------------------------------------
// bls_datapath
// endpoint ordering, error term setup, pixel stepping and output register
// ----------------------------------------------------------------------------
`default_nettype none

module bls_datapath
    import bls_pkg::*;
(
    input  wire logic                         clk,
    input  wire bls_cmd_t                     cmd,
    output bls_stat_t                         stat,
    input  wire logic signed [COORD_BITS-1:0] first_x,
    input  wire logic signed [COORD_BITS-1:0] first_y,
    input  wire logic signed [COORD_BITS-1:0] second_x,
    input  wire logic signed [COORD_BITS-1:0] second_y,
    input  wire logic [COLOR_BITS-1:0]        line_color,
    output logic signed [COORD_BITS-1:0]      pixel_x,
    output logic signed [COORD_BITS-1:0]      pixel_y,
    output logic [COLOR_BITS-1:0]             pixel_color,
    output logic                              last_pixel
);

    logic signed [COORD_BITS-1:0] cur_x_reg,   cur_x_next;
    logic signed [COORD_BITS-1:0] cur_y_reg,   cur_y_next;
    logic signed [COORD_BITS-1:0] end_x_reg,   end_x_next;
    logic signed [COORD_BITS-1:0] end_y_reg,   end_y_next;
    logic                         vert_reg,    vert_next;
    logic signed [COORD_BITS-1:0] stop_reg,    stop_next;
    logic [MODE_BITS-1:0]         mode_reg,    mode_next;
    logic signed [ERR_BITS-1:0]   err_reg,     err_next;
    logic signed [ERR_BITS-1:0]   sinc_reg,    sinc_next;
    logic signed [ERR_BITS-1:0]   dinc_reg,    dinc_next;
    logic [COLOR_BITS-1:0]        color_reg,   color_next;

    logic signed [COORD_BITS-1:0] px_reg;
    logic signed [COORD_BITS-1:0] py_reg;
    logic [COLOR_BITS-1:0]        pc_reg;
    logic                         pl_reg;

    logic signed [ERR_BITS-1:0]   dx_w;
    logic signed [ERR_BITS-1:0]   dy_w;
    logic signed [ERR_BITS-1:0]   ady_w;
    logic signed [ERR_BITS-1:0]   major_w;
    logic signed [ERR_BITS-1:0]   minor_w;
    logic                         shallow_w;
    logic                         rising_w;
    logic                         diag_w;

    // setup arithmetic on the ordered endpoints
    always_comb
    begin
        dx_w      = {{EXT_BITS{end_x_reg[COORD_BITS-1]}}, end_x_reg}
                  - {{EXT_BITS{cur_x_reg[COORD_BITS-1]}}, cur_x_reg};
        dy_w      = {{EXT_BITS{end_y_reg[COORD_BITS-1]}}, end_y_reg}
                  - {{EXT_BITS{cur_y_reg[COORD_BITS-1]}}, cur_y_reg};
        ady_w     = dy_w[ERR_BITS-1] ? -dy_w : dy_w;
        shallow_w = (ady_w < dx_w);
        rising_w  = shallow_w ? !dy_w[ERR_BITS-1] : (dy_w > ERR_ZERO);
        minor_w   = shallow_w ? ady_w : dx_w;
        major_w   = shallow_w ? dx_w : ady_w;
    end

    assign diag_w    = (err_reg > ERR_ZERO);
    assign stat.last = ((mode_reg == MODE_SHALLOW_UP) || (mode_reg == MODE_SHALLOW_DOWN))
                     ? (cur_x_reg == stop_reg) : (cur_y_reg == stop_reg);

    always_comb
    begin
        cur_x_next = cur_x_reg;
        cur_y_next = cur_y_reg;
        end_x_next = end_x_reg;
        end_y_next = end_y_reg;
        vert_next  = vert_reg;
        stop_next  = stop_reg;
        mode_next  = mode_reg;
        err_next   = err_reg;
        sinc_next  = sinc_reg;
        dinc_next  = dinc_reg;
        color_next = color_reg;

        if (cmd.load)
        begin
            color_next = line_color;
            if (first_x == second_x)
            begin
                vert_next  = 1'b1;
                cur_x_next = first_x;
                end_x_next = first_x;
                cur_y_next = (first_y < second_y) ? first_y : second_y;
                end_y_next = (first_y > second_y) ? first_y : second_y;
            end
            else if (first_x < second_x)
            begin
                vert_next  = 1'b0;
                cur_x_next = first_x;
                cur_y_next = first_y;
                end_x_next = second_x;
                end_y_next = second_y;
            end
            else
            begin
                vert_next  = 1'b0;
                cur_x_next = second_x;
                cur_y_next = second_y;
                end_x_next = first_x;
                end_y_next = first_y;
            end
        end
        else if (cmd.setup)
        begin
            if (vert_reg)
            begin
                mode_next = MODE_VERT;
                stop_next = end_y_reg;
                err_next  = ERR_ZERO;
                sinc_next = ERR_ZERO;
                dinc_next = ERR_ZERO;
            end
            else
            begin
                if (shallow_w)
                begin
                    mode_next = rising_w ? MODE_SHALLOW_UP : MODE_SHALLOW_DOWN;
                    stop_next = end_x_reg;
                end
                else
                begin
                    mode_next = rising_w ? MODE_STEEP_UP : MODE_STEEP_DOWN;
                    stop_next = end_y_reg;
                end
                err_next  = (minor_w <<< 1) - major_w;
                sinc_next = minor_w <<< 1;
                dinc_next = (minor_w - major_w) <<< 1;
            end
        end
        else if (cmd.emit && !stat.last)
        begin
            err_next = err_reg + (diag_w ? dinc_reg : sinc_reg);
            unique case (mode_reg)
                MODE_SHALLOW_UP:
                begin
                    cur_x_next = cur_x_reg + COORD_ONE;
                    if (diag_w)
                    begin
                        cur_y_next = cur_y_reg + COORD_ONE;
                    end
                end
                MODE_STEEP_UP:
                begin
                    cur_y_next = cur_y_reg + COORD_ONE;
                    if (diag_w)
                    begin
                        cur_x_next = cur_x_reg + COORD_ONE;
                    end
                end
                MODE_SHALLOW_DOWN:
                begin
                    cur_x_next = cur_x_reg + COORD_ONE;
                    if (diag_w)
                    begin
                        cur_y_next = cur_y_reg - COORD_ONE;
                    end
                end
                MODE_STEEP_DOWN:
                begin
                    cur_y_next = cur_y_reg - COORD_ONE;
                    if (diag_w)
                    begin
                        cur_x_next = cur_x_reg + COORD_ONE;
                    end
                end
                default:
                begin
                    cur_y_next = cur_y_reg + COORD_ONE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        cur_x_reg <= cur_x_next;
        cur_y_reg <= cur_y_next;
        end_x_reg <= end_x_next;
        end_y_reg <= end_y_next;
        vert_reg  <= vert_next;
        stop_reg  <= stop_next;
        mode_reg  <= mode_next;
        err_reg   <= err_next;
        sinc_reg  <= sinc_next;
        dinc_reg  <= dinc_next;
        color_reg <= color_next;
    end

    // output register
    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            px_reg <= cur_x_reg;
            py_reg <= cur_y_reg;
            pc_reg <= color_reg;
            pl_reg <= stat.last;
        end
    end

    assign pixel_x     = px_reg;
    assign pixel_y     = py_reg;
    assign pixel_color = pc_reg;
    assign last_pixel  = pl_reg;

endmodule

`default_nettype wire
